[hdl/mwpo_pkg.sv]
`default_nettype none

package mwpo_pkg;

	// Waveform selector codes. The fourth code selects silence.
	typedef enum logic [1:0] {
		WAVE_SINE   = 2'd0,
		WAVE_SAW    = 2'd1,
		WAVE_SQUARE = 2'd2
	} wave_t;

	// Configuration register indexes.
	localparam logic REG_WAVEFORM   = 1'b0;
	localparam logic REG_STEP_SCALE = 1'b1;

	localparam int FREQ_W   = 26;
	localparam int OFFSET_W = 34;
	localparam int SCALE_W  = 39;
	localparam int SAMPLE_W = 18;
	localparam int SCALE_LO_W = 20;
	localparam int SCALE_HI_W = SCALE_W - SCALE_LO_W;
	localparam int PROD_W   = 56;

	// Phase plus offset is formed in units of 2^-48 turn.
	localparam int UNIT_BITS = 48;
	localparam int V_W       = 51;

	localparam logic [SCALE_W-1:0] STEP_SCALE_RESET = 39'd5864062015;
	localparam logic [1:0]         WAVEFORM_RESET   = 2'd0;

	localparam logic signed [V_W-1:0] V_HALF_TURN = 51'sd140737488355328;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_PLUS_ONE  = 18'sd32768;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MINUS_ONE = -18'sd32768;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_ZERO      = 18'sd0;
	localparam logic signed [19:0]         SAW_MAX          = 20'sd131071;
	localparam logic signed [19:0]         SAW_MIN          = -20'sd131072;
	localparam logic signed [19:0]         SAW_BIAS         = 20'sd32768;

	localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

	// Control that travels with one item between stages.
	typedef struct packed {
		logic valid;
		logic trigger;
	} mwpo_ctl_t;

	// Quarter-wave sine entry, round(32768*sin(2*pi*m/2^tbits)), from a truncated
	// Q30 Taylor series. Evaluated only while the table is built at elaboration.
	function automatic logic [15:0] quarter_sine(input longint unsigned m, input int tbits);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned prod;
		longint          sum;
		x    = (m * TWO_PI_Q30) >> tbits;
		x2   = (x * x) >> 30;
		term = x;
		sum  = longint'(x);
		for (int k = 1; k <= 8; k++) begin
			prod = (term * x2) >> 30;
			case (k)
				1: term = prod / 6;
				2: term = prod / 20;
				3: term = prod / 42;
				4: term = prod / 72;
				5: term = prod / 110;
				6: term = prod / 156;
				7: term = prod / 210;
				default: term = prod / 272;
			endcase
			if ((k % 2) == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		return 16'((sum + 16384) >>> 15);
	endfunction

endpackage

`default_nettype wire

[hdl/mwpo_step.sv]
`default_nettype none

// Phase increment: frequency times step_scale, split into two partial
// products in the first stage and summed in the second.
module mwpo_step #(
	parameter int PHASE_BITS = 32
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   en,
	input  wire mwpo_pkg::mwpo_ctl_t                    ctl_in,
	input  wire logic [mwpo_pkg::FREQ_W-1:0]            frequency,
	input  wire logic signed [mwpo_pkg::OFFSET_W-1:0]   phase_offset,
	input  wire logic [mwpo_pkg::SCALE_W-1:0]           step_scale,
	output mwpo_pkg::mwpo_ctl_t                         ctl_s2,
	output logic [PHASE_BITS-1:0]                       step_s2,
	output logic signed [mwpo_pkg::OFFSET_W-1:0]        offset_s2
);

	localparam int LO_W = mwpo_pkg::FREQ_W + mwpo_pkg::SCALE_LO_W;
	localparam int HI_W = mwpo_pkg::FREQ_W + mwpo_pkg::SCALE_HI_W;

	mwpo_pkg::mwpo_ctl_t                  ctl_s1;
	logic [LO_W-1:0]                      prod_lo_s1;
	logic [HI_W-1:0]                      prod_hi_s1;
	logic signed [mwpo_pkg::OFFSET_W-1:0] offset_s1;
	logic [mwpo_pkg::PROD_W-1:0]          prod_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_lo_s1 <= LO_W'(frequency) *
				LO_W'(step_scale[mwpo_pkg::SCALE_LO_W-1:0]);
			prod_hi_s1 <= HI_W'(frequency) *
				HI_W'(step_scale[mwpo_pkg::SCALE_W-1:mwpo_pkg::SCALE_LO_W]);
			offset_s1  <= phase_offset;
			step_s2    <= prod_sum[mwpo_pkg::PROD_W-1 -: PHASE_BITS];
			offset_s2  <= offset_s1;
		end
	end

	// Only the low 56 bits of the product reach the wrapped phase.
	assign prod_sum = mwpo_pkg::PROD_W'(prod_lo_s1) +
		(mwpo_pkg::PROD_W'(prod_hi_s1) << mwpo_pkg::SCALE_LO_W);

endmodule

`default_nettype wire

[hdl/mwpo_phase.sv]
`default_nettype none

// Phase accumulator with retrigger. Picks the phase before or after the
// advance depending on the waveform.
module mwpo_phase #(
	parameter int PHASE_BITS = 32
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 en,
	input  wire mwpo_pkg::mwpo_ctl_t                  ctl_s2,
	input  wire logic [PHASE_BITS-1:0]                step_s2,
	input  wire logic signed [mwpo_pkg::OFFSET_W-1:0] offset_s2,
	input  wire logic [1:0]                           waveform,
	output logic                                      valid_s3,
	output logic [PHASE_BITS-1:0]                     phase_s3,
	output logic signed [mwpo_pkg::OFFSET_W-1:0]      offset_s3
);

	logic [PHASE_BITS-1:0] phase_acc_q;
	logic                  trigger_was_high_q;
	logic [PHASE_BITS-1:0] phase_cur;
	logic [PHASE_BITS-1:0] phase_next;

	always_comb begin
		phase_cur  = (ctl_s2.trigger && !trigger_was_high_q) ? '0 : phase_acc_q;
		phase_next = phase_cur + step_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_acc_q        <= '0;
			trigger_was_high_q <= 1'b0;
			valid_s3           <= 1'b0;
		end else if (en) begin
			valid_s3 <= ctl_s2.valid;
			if (ctl_s2.valid) begin
				phase_acc_q        <= phase_next;
				trigger_was_high_q <= ctl_s2.trigger;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			phase_s3  <= (waveform == mwpo_pkg::WAVE_SINE) ? phase_cur : phase_next;
			offset_s3 <= offset_s2;
		end
	end

endmodule

`default_nettype wire

[hdl/mwpo_wave.sv]
`default_nettype none

// Waveform shaping: phase plus offset, quarter-wave sine table, sawtooth
// and square, and the output register.
module mwpo_wave #(
	parameter int PHASE_BITS      = 32,
	parameter int SINE_TABLE_BITS = 10
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 en,
	input  wire logic                                 valid_s3,
	input  wire logic [PHASE_BITS-1:0]                phase_s3,
	input  wire logic signed [mwpo_pkg::OFFSET_W-1:0] offset_s3,
	input  wire logic [1:0]                           waveform,
	output logic                                      out_valid,
	output logic signed [mwpo_pkg::SAMPLE_W-1:0]      sample
);

	localparam int QSIZE  = 1 << (SINE_TABLE_BITS - 2);
	localparam int QENT   = QSIZE + 1;
	localparam int ADDR_W = SINE_TABLE_BITS - 1;

	typedef logic [15:0] qrom_t [QENT];

	function automatic qrom_t build_rom();
		qrom_t r;
		for (int i = 0; i < QENT; i++) begin
			r[i] = mwpo_pkg::quarter_sine(64'(i), SINE_TABLE_BITS);
		end
		return r;
	endfunction

	localparam qrom_t QROM = build_rom();

	logic                                 valid_s4;
	logic signed [mwpo_pkg::V_W-1:0]      v_s4;
	logic                                 valid_s5;
	logic [15:0]                          rom_s5;
	logic                                 neg_s5;
	logic signed [mwpo_pkg::SAMPLE_W-1:0] saw_s5;
	logic                                 sq_low_s5;

	logic signed [mwpo_pkg::V_W-1:0]      v_sum;
	logic [SINE_TABLE_BITS-1:0]           tbl_idx;
	logic [SINE_TABLE_BITS-3:0]           quarter_pos;
	logic [ADDR_W-1:0]                    rom_addr;
	logic signed [18:0]                   v_top;
	logic signed [19:0]                   saw_full;
	logic signed [mwpo_pkg::SAMPLE_W-1:0] saw_sat;
	logic signed [mwpo_pkg::SAMPLE_W-1:0] sine_val;
	logic signed [mwpo_pkg::SAMPLE_W-1:0] sample_d;

	always_comb begin
		v_sum = (mwpo_pkg::V_W'(phase_s3) << (mwpo_pkg::UNIT_BITS - PHASE_BITS)) +
			(mwpo_pkg::V_W'(offset_s3) <<< 16);

		tbl_idx     = v_s4[mwpo_pkg::UNIT_BITS-1 -: SINE_TABLE_BITS];
		quarter_pos = tbl_idx[SINE_TABLE_BITS-3:0];
		// Second and fourth quarters read the table backward.
		if (tbl_idx[SINE_TABLE_BITS-2]) begin
			rom_addr = ADDR_W'(QSIZE) - ADDR_W'(quarter_pos);
		end else begin
			rom_addr = ADDR_W'(quarter_pos);
		end

		v_top    = v_s4[mwpo_pkg::V_W-1:32];
		saw_full = 20'(v_top) - mwpo_pkg::SAW_BIAS;
		if (saw_full > mwpo_pkg::SAW_MAX) begin
			saw_sat = mwpo_pkg::SAMPLE_W'(mwpo_pkg::SAW_MAX);
		end else if (saw_full < mwpo_pkg::SAW_MIN) begin
			saw_sat = mwpo_pkg::SAMPLE_W'(mwpo_pkg::SAW_MIN);
		end else begin
			saw_sat = mwpo_pkg::SAMPLE_W'(saw_full);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4  <= 1'b0;
			valid_s5  <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			valid_s4  <= valid_s3;
			valid_s5  <= valid_s4;
			out_valid <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s4      <= v_sum;
			rom_s5    <= QROM[rom_addr];
			neg_s5    <= tbl_idx[SINE_TABLE_BITS-1];
			saw_s5    <= saw_sat;
			sq_low_s5 <= (v_s4 > mwpo_pkg::V_HALF_TURN);
			sample    <= sample_d;
		end
	end

	always_comb begin
		sine_val = neg_s5 ? -$signed({2'b00, rom_s5}) : $signed({2'b00, rom_s5});
		case (waveform)
			mwpo_pkg::WAVE_SINE:   sample_d = sine_val;
			mwpo_pkg::WAVE_SAW:    sample_d = saw_s5;
			mwpo_pkg::WAVE_SQUARE: sample_d = sq_low_s5 ? mwpo_pkg::SAMPLE_MINUS_ONE
			                                            : mwpo_pkg::SAMPLE_PLUS_ONE;
			default:               sample_d = mwpo_pkg::SAMPLE_ZERO;
		endcase
	end

endmodule

`default_nettype wire

[hdl/multiwave_phase_oscillator_unit.sv]
// Multi-waveform phase oscillator (sine, sawtooth, square) with retrigger.
// Input channel: in_valid / in_stall carry one transaction per sample with
// frequency (Hz, 8 fraction bits), phase_offset (2^-32 turn) and trigger.
// Output channel: out_valid / out_stall carry one sample per input
// transaction, signed with 15 fraction bits.
// Throughput is one transaction per clock while the receiver does not stall.
// A transaction passes the step multiply (s1, s2), the phase accumulator
// (s3), the phase-plus-offset add (s4), and the sine table read and output
// select (s5 and the output register, which then holds its result).
// The phase accumulator is a single adder that feeds back through phase_acc_q.
// When the receiver stalls with a sample pending, the whole pipeline holds
// and in_stall rises in the same cycle; nothing is dropped or repeated.
// Reset clears all valid flags, zeroes the phase and the trigger history,
// and loads waveform = sine and the default step_scale.
// Registers are written through cfg_wr_en / cfg_index / cfg_data; the user must
// write them only while no transaction is in flight, which the block does not enforce.
`default_nettype none

module multiwave_phase_oscillator_unit #(
	parameter int PHASE_BITS      = 32,
	parameter int SINE_TABLE_BITS = 10
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,

	input  wire logic                                 cfg_wr_en,
	input  wire logic                                 cfg_index,
	input  wire logic [mwpo_pkg::SCALE_W-1:0]         cfg_data,

	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [mwpo_pkg::FREQ_W-1:0]          frequency,
	input  wire logic signed [mwpo_pkg::OFFSET_W-1:0] phase_offset,
	input  wire logic                                 trigger,

	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed [mwpo_pkg::SAMPLE_W-1:0]      sample
);

	logic [1:0]                           waveform_q;
	logic [mwpo_pkg::SCALE_W-1:0]         step_scale_q;
	logic                                 en;
	mwpo_pkg::mwpo_ctl_t                  ctl_in;
	mwpo_pkg::mwpo_ctl_t                  ctl_s2;
	logic [PHASE_BITS-1:0]                step_s2;
	logic signed [mwpo_pkg::OFFSET_W-1:0] offset_s2;
	logic                                 valid_s3;
	logic [PHASE_BITS-1:0]                phase_s3;
	logic signed [mwpo_pkg::OFFSET_W-1:0] offset_s3;

	// The pipeline moves whenever the output register is empty or being
	// drained, so a new transaction can enter as a finished one is taken, but not while it is stalled.
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	always_comb begin
		ctl_in.valid   = in_valid;
		ctl_in.trigger = trigger;
	end

	// Configuration registers. Writes are masked to the register width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waveform_q   <= mwpo_pkg::WAVEFORM_RESET;
			step_scale_q <= mwpo_pkg::STEP_SCALE_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				mwpo_pkg::REG_WAVEFORM:   waveform_q   <= cfg_data[1:0];
				mwpo_pkg::REG_STEP_SCALE: step_scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	mwpo_step #(
		.PHASE_BITS(PHASE_BITS)
	) u_step (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.ctl_in      (ctl_in),
		.frequency   (frequency),
		.phase_offset(phase_offset),
		.step_scale  (step_scale_q),
		.ctl_s2      (ctl_s2),
		.step_s2     (step_s2),
		.offset_s2   (offset_s2)
	);

	mwpo_phase #(
		.PHASE_BITS(PHASE_BITS)
	) u_phase (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.ctl_s2   (ctl_s2),
		.step_s2  (step_s2),
		.offset_s2(offset_s2),
		.waveform (waveform_q),
		.valid_s3 (valid_s3),
		.phase_s3 (phase_s3),
		.offset_s3(offset_s3)
	);

	mwpo_wave #(
		.PHASE_BITS     (PHASE_BITS),
		.SINE_TABLE_BITS(SINE_TABLE_BITS)
	) u_wave (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_s3 (valid_s3),
		.phase_s3 (phase_s3),
		.offset_s3(offset_s3),
		.waveform (waveform_q),
		.out_valid(out_valid),
		.sample   (sample)
	);

endmodule

`default_nettype wire

[test/oscillator_sample_checker.sv]
`timescale 1ns / 1ps

module oscillator_sample_checker (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_wr_en,
	input  wire logic                                 cfg_index,
	input  wire logic [mwpo_pkg::SCALE_W-1:0]         cfg_data,
	input  wire logic                                 in_valid,
	input  wire logic                                 in_stall,
	input  wire logic [mwpo_pkg::FREQ_W-1:0]          frequency,
	input  wire logic signed [mwpo_pkg::OFFSET_W-1:0] phase_offset,
	input  wire logic                                 trigger,
	input  wire logic                                 out_valid,
	input  wire logic                                 out_stall,
	input  wire logic signed [mwpo_pkg::SAMPLE_W-1:0] sample,
	output int                                        mismatches,
	output int                                        outstanding
);
	import mwpo_pkg::*;

	localparam int              TABLE_BITS   = 10;
	localparam int              QUARTER      = 1 << (TABLE_BITS - 2);
	localparam longint unsigned TURN_Q30     = 64'd6746518852;
	localparam int              REPORT_LIMIT = 10;
	localparam int              FIFO_DEPTH   = 64;

	logic [1:0]                 wave_sel;
	logic [SCALE_W-1:0]         scale;
	logic [31:0]                phase;
	logic                       trigger_seen;
	logic signed [SAMPLE_W-1:0] sine_quarter [0:QUARTER];
	logic signed [SAMPLE_W-1:0] expected_samples [0:FIFO_DEPTH-1];
	int                         wr_count;
	int                         rd_count;
	logic signed [SAMPLE_W-1:0] oldest;
	int                         error_count = 0;

	assign mismatches = error_count;

	// First quadrant of the sine table: truncated Q30 Taylor series, rounded to Q15.
	function automatic logic signed [SAMPLE_W-1:0] quarter_wave(input int m);
		longint unsigned angle;
		longint unsigned angle_sq;
		longint unsigned term;
		longint          acc;
		int              k;
		angle = longint'(m);
		angle = (angle * TURN_Q30) >> TABLE_BITS;
		angle_sq = (angle * angle) >> 30;
		term = angle;
		acc = longint'(angle);
		for (k = 1; k <= 8; k++) begin
			term = ((term * angle_sq) >> 30) / longint'((2 * k) * (2 * k + 1));
			if (k % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		return SAMPLE_W'((acc + 16384) >>> 15);
	endfunction

	initial begin
		for (int m = 0; m <= QUARTER; m++) begin
			sine_quarter[m] = quarter_wave(m);
		end
	end

	// Applies one input transaction to the oscillator state and returns its sample.
	function automatic logic signed [SAMPLE_W-1:0] oscillate(
		input logic [FREQ_W-1:0]          freq,
		input logic signed [OFFSET_W-1:0] offset,
		input logic                       trig
	);
		logic [63:0]                product;
		longint                     turn_sum;
		longint                     saw;
		logic [TABLE_BITS-1:0]      index;
		logic signed [SAMPLE_W-1:0] mag;
		logic signed [SAMPLE_W-1:0] value;
		if (trig && !trigger_seen) begin
			phase = '0;
		end
		trigger_seen = trig;
		product = 64'(freq) * 64'(scale);
		value = '0;
		if (wave_sel == WAVE_SINE) begin
			turn_sum = (longint'(phase) <<< 16) + (longint'(offset) <<< 16);
			index = turn_sum[47:38];
			// Second and fourth quarters read the table backward.
			mag = index[TABLE_BITS-2] ? sine_quarter[QUARTER - index[TABLE_BITS-3:0]]
				: sine_quarter[index[TABLE_BITS-3:0]];
			value = index[TABLE_BITS-1] ? -mag : mag;
			phase = phase + product[55:24];
		end else begin
			phase = phase + product[55:24];
			turn_sum = (longint'(phase) <<< 16) + (longint'(offset) <<< 16);
			case (wave_sel)
				WAVE_SAW: begin
					saw = (turn_sum >>> 32) - 32768;
					if (saw > 131071) begin
						saw = 131071;
					end else if (saw < -131072) begin
						saw = -131072;
					end
					value = SAMPLE_W'(saw);
				end
				WAVE_SQUARE: begin
					value = (turn_sum > (64'sd1 <<< 47)) ? -18'sd32768 : 18'sd32768;
				end
				default: begin
					value = '0;
				end
			endcase
		end
		return value;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_sel = WAVE_SINE;
			scale = STEP_SCALE_RESET;
			phase = '0;
			trigger_seen = 1'b0;
			wr_count = 0;
			rd_count = 0;
			outstanding <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_WAVEFORM: wave_sel = cfg_data[1:0];
					REG_STEP_SCALE: scale = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				expected_samples[wr_count % FIFO_DEPTH] =
					oscillate(frequency, phase_offset, trigger);
				wr_count++;
			end
			if (out_valid && !out_stall) begin
				if (wr_count == rd_count) begin
					error_count++;
					if (error_count <= REPORT_LIMIT) begin
						$display("unexpected sample %0d with no transaction pending", sample);
					end
				end else begin
					oldest = expected_samples[rd_count % FIFO_DEPTH];
					rd_count++;
					if (sample !== oldest) begin
						error_count++;
						if (error_count <= REPORT_LIMIT) begin
							$display("sample mismatch: expected %0d, got %0d", oldest, sample);
						end
					end
				end
			end
			outstanding <= wr_count - rd_count;
		end
	end

endmodule

[test/multiwave_phase_oscillator_unit_test.sv]
`timescale 1ns / 1ps

module multiwave_phase_oscillator_unit_test;
	import mwpo_pkg::*;

	// The waveform register has a fourth code with no name in the package; it
	// produces silence while the phase keeps running.
	localparam logic [1:0]         WAVE_SILENT   = 2'd3;
	localparam logic [SCALE_W-1:0] SCALE_MIN     = 39'd733007752;
	localparam logic [SCALE_W-1:0] SCALE_MAX     = 39'd281474976711;
	localparam int                 RANDOM_ITEMS  = 1100;
	localparam int                 PHASES        = 8;
	localparam int                 SETTLE_CYCLES = 10;
	localparam int                 IDLE_LIMIT    = 2000;

	typedef enum int {
		RX_OPEN,
		RX_LIGHT,
		RX_HEAVY,
		RX_PERIODIC
	} rx_mode_t;

	logic                       clk          = 1'b0;
	logic                       arst_n       = 1'b0;
	logic                       cfg_wr_en    = 1'b0;
	logic                       cfg_index    = 1'b0;
	logic [SCALE_W-1:0]         cfg_data     = '0;
	logic                       in_valid     = 1'b0;
	logic                       in_stall;
	logic [FREQ_W-1:0]          frequency    = '0;
	logic signed [OFFSET_W-1:0] phase_offset = '0;
	logic                       trigger      = 1'b0;
	logic                       out_valid;
	logic                       out_stall    = 1'b0;
	logic signed [SAMPLE_W-1:0] sample;

	int       mismatches;
	int       outstanding;
	int       idle_cycles   = 0;
	int       burst_left    = 0;
	int       stretch_left  = 0;
	rx_mode_t rx_mode       = RX_OPEN;
	logic     trigger_level = 1'b0;

	multiwave_phase_oscillator_unit u_top (.*);

	oscillator_sample_checker u_checker (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// The receiver works in stretches of random length. Each stretch has its
	// own stall behavior: fully open, occasional stalls, mostly stalled, or a
	// fixed two-in-three pattern, so stalls land on every pipeline stage.
	always @(posedge clk) begin
		if (stretch_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			stretch_left <= $urandom_range(10, 80);
			out_stall <= 1'b0;
		end else begin
			stretch_left <= stretch_left - 1;
			case (rx_mode)
				RX_OPEN: out_stall <= 1'b0;
				RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= (stretch_left % 3 != 0);
			endcase
		end
	end

	// Watchdog: any accepted transaction, taken sample or register write counts as progress.
	// A long run of cycles without progress means the block has hung.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("status: fail");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// After each accepted transaction the sender either continues its burst or
	// drops valid for a random gap and then picks a new burst length. Some
	// bursts are long, which gives stretches with no sender idling at all.
	task automatic pace_sender();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
				: $urandom_range(0, 20);
		end
	endtask

	// Presents one input transaction and holds it until the block takes it.
	task automatic send_sample(
		input logic [FREQ_W-1:0]   freq,
		input logic [OFFSET_W-1:0] offset,
		input logic                trig
	);
		frequency <= freq;
		phase_offset <= offset;
		trigger <= trig;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		pace_sender();
	endtask

	// Stops sending and waits until every predicted sample has come out, then
	// lets the pipeline settle so that register writes find the block idle.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// A write lowers the enable again and waits before returning, so that back-to-back
	// writes never raise and lower the enable in the same time step.
	task automatic write_register(input logic index, input logic [SCALE_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// Field extremes and the corner cases of each waveform. A rising trigger
	// edge parks the phase at zero and zero frequency keeps it there, so
	// the half-turn offsets land exactly on and just past the square wave threshold.
	task automatic directed_set();
		send_sample({FREQ_W{1'b1}}, 34'h1_FFFF_FFFF, 1'b1);
		send_sample(26'd49152000, 34'h2_0000_0000, 1'b1);
		send_sample(26'd0, 34'h1_0000_0000, 1'b0);
		send_sample(26'd0, 34'h0_8000_0000, 1'b1);
		send_sample(26'd0, 34'h0_8000_0001, 1'b1);
		send_sample(26'd112640, 34'h3_0000_0000, 1'b0);
		send_sample(26'd12800000, 34'h0_0000_0000, 1'b0);
	endtask

	task automatic run_directed();
		// Sine with the registers at their reset values.
		directed_set();
		// Sawtooth, written with junk in the upper data bits to check masking.
		wait_for_results();
		write_register(REG_WAVEFORM, {{(SCALE_W - 2){1'b1}}, WAVE_SAW});
		directed_set();
		// Square at the largest step scale; maximum frequency wraps the product.
		wait_for_results();
		write_register(REG_STEP_SCALE, SCALE_MAX);
		write_register(REG_WAVEFORM, SCALE_W'(WAVE_SQUARE));
		directed_set();
		// The unused waveform code at the smallest step scale.
		wait_for_results();
		write_register(REG_STEP_SCALE, SCALE_MIN);
		write_register(REG_WAVEFORM, SCALE_W'(WAVE_SILENT));
		directed_set();
	endtask

	// One random transaction. Frequencies are mostly in the audio band with a
	// share of full-width values; offsets are mostly within one turn, with
	// some full-width values that push the sawtooth into saturation. The
	// trigger level flips now and then, giving rising edges and held levels.
	task automatic random_sample();
		logic [FREQ_W-1:0]   freq;
		logic [OFFSET_W-1:0] offset;
		case ($urandom_range(0, 9))
			0: freq = '0;
			1: freq = '1;
			2, 3: freq = FREQ_W'($urandom);
			default: freq = FREQ_W'($urandom_range(0, 20000 * 256));
		endcase
		case ($urandom_range(0, 9))
			0: offset = OFFSET_W'({$urandom, $urandom});
			1: begin
				case ($urandom_range(0, 3))
					0: offset = 34'h1_FFFF_FFFF;
					1: offset = 34'h2_0000_0000;
					2: offset = 34'h1_0000_0000;
					default: offset = 34'h3_0000_0000;
				endcase
			end
			2: offset = '0;
			default: offset = OFFSET_W'(longint'($urandom) - longint'($urandom));
		endcase
		if ($urandom_range(0, 7) == 0) begin
			trigger_level = ~trigger_level;
		end
		send_sample(freq, offset, trigger_level);
	endtask

	// Random phases. The first four visit every waveform code and the step
	// scale at its minimum, maximum, reset value and an unconstrained 39-bit
	// value; the rest draw both registers at random. Every phase starts with
	// the block drained, so the sender pauses until all results are in.
	task automatic run_random();
		logic [SCALE_W-1:0] wave_word;
		logic [SCALE_W-1:0] scale_word;
		longint unsigned    span;
		longint unsigned    draw;
		span = SCALE_MAX - SCALE_MIN + 1;
		for (int p = 0; p < PHASES; p++) begin
			draw = {$urandom, $urandom};
			case (p)
				0: begin
					wave_word = SCALE_W'(WAVE_SINE);
					scale_word = SCALE_MIN;
				end
				1: begin
					wave_word = SCALE_W'(WAVE_SAW);
					scale_word = SCALE_MAX;
				end
				2: begin
					wave_word = SCALE_W'(WAVE_SQUARE);
					scale_word = STEP_SCALE_RESET;
				end
				3: begin
					wave_word = SCALE_W'(WAVE_SILENT);
					scale_word = SCALE_W'(draw);
				end
				default: begin
					wave_word = SCALE_W'({$urandom, $urandom});
					scale_word = SCALE_W'(SCALE_MIN + draw % span);
				end
			endcase
			wait_for_results();
			write_register(REG_WAVEFORM, wave_word);
			write_register(REG_STEP_SCALE, scale_word);
			for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
				random_sample();
			end
		end
	endtask

	// Reset is held from time zero, released once, and never asserted again.
	// The checker follows the register writes and transactions on its own.
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random();
		wait_for_results();
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

[filelist.f]
hdl/mwpo_pkg.sv
hdl/mwpo_step.sv
hdl/mwpo_phase.sv
hdl/mwpo_wave.sv
hdl/multiwave_phase_oscillator_unit.sv
test/oscillator_sample_checker.sv
test/multiwave_phase_oscillator_unit_test.sv
